// ===== rtl/vefc_pkg.sv =====
// ---------------------------------------------------------------------------
// vefc_pkg
// Shared types and constants for the vector element float converter.
// ---------------------------------------------------------------------------
package vefc_pkg;

   typedef enum logic [1:0] {
      ELEM_F32  = 2'd0,
      ELEM_F64  = 2'd1,
      ELEM_F16  = 2'd2,
      ELEM_BF16 = 2'd3
   } elem_type;

   localparam logic [31:0] F32_SIGN     = 32'h8000_0000;
   localparam logic [31:0] F32_INF      = 32'h7F80_0000;
   localparam logic [31:0] HALF_INF_POS = 32'd31 << 23;
   localparam logic [31:0] HALF_TRUNC   = ~32'hFFF;
   localparam logic [31:0] BF16_HALF    = 32'h0000_7FFF;

   // Single-precision result of stage one, before its rounding increment.
   typedef struct packed {
      logic [63:0] raw;
      logic [1:0]  etype;
      logic        sign;
      logic        special;   // result fixed: NaN, inf or zero
      logic [31:0] fixed_val;
      logic [23:0] q;         // truncated magnitude (one extra bit for overflow)
      logic        round_up;
   } s1_data_type;

   typedef struct packed {
      logic [63:0] raw;
      logic [1:0]  etype;
      logic [31:0] single;
   } s2_data_type;

endpackage

// ===== rtl/vefc_to_single.sv =====
// ---------------------------------------------------------------------------
// vefc_to_single
// Two stages: align and sticky, then round to nearest even and saturate.
// ---------------------------------------------------------------------------
module vefc_to_single (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [63:0]               in_raw,
   input  logic [1:0]                in_etype,
   output logic                      out_valid,
   output vefc_pkg::s2_data_type     out_data
);
   import vefc_pkg::*;

   logic        v1_ff, v1_in, v2_ff, v2_in;
   s1_data_type d1_ff, d1_in;
   s2_data_type d2_ff, d2_in;

   logic [10:0] ex;
   logic [51:0] frac;
   logic [52:0] mant;
   logic [11:0] sh;
   logic [5:0]  sh6;
   logic [52:0] q_full;
   logic [52:0] rem_mask;
   logic [52:0] rem;
   logic [52:0] half_bit;
   logic        gt_half, eq_half;
   logic [24:0] q_sum;

   always_comb begin
      ex   = in_raw[62:52];
      frac = in_raw[51:0];
      mant = {1'b1, frac};
      d1_in = '0;
      d1_in.raw   = in_raw;
      d1_in.etype = in_etype;
      d1_in.sign  = in_raw[63];
      sh  = 12'd926 - {1'b0, ex};
      sh6 = sh[5:0];
      q_full = '0; rem = '0; half_bit = '0; rem_mask = '0;
      gt_half = 1'b0; eq_half = 1'b0;
      if (ex == 11'h7FF) begin
         d1_in.special = 1'b1;
         d1_in.fixed_val = (frac == '0) ? F32_INF
                                        : (F32_INF | 32'h0040_0000 | {9'd0, frac[51:29]});
      end else if (ex == 11'd0) begin
         d1_in.special = 1'b1;
      end else if (ex >= 11'd1151) begin
         d1_in.special = 1'b1;
         d1_in.fixed_val = F32_INF;
      end else if (ex >= 11'd897) begin
         // normal single: magnitude travels in norm_mag, round on the low 29 bits
         gt_half = frac[28] && (frac[27:0] != '0);
         eq_half = frac[28] && (frac[27:0] == '0);
         d1_in.round_up = gt_half || (eq_half && frac[29]);
      end else if (sh >= 12'd54) begin
         d1_in.special = 1'b1;   // shift of 54 or more: all bits dropped, below half
      end else begin
         q_full   = mant >> sh6;
         rem_mask = (53'd1 << sh6) - 53'd1;
         rem      = mant & rem_mask;
         half_bit = 53'd1 << (sh6 - 6'd1);
         gt_half  = rem > half_bit;
         eq_half  = rem == half_bit;
         d1_in.q  = q_full[23:0];
         d1_in.round_up = gt_half || (eq_half && q_full[0]);
      end
   end

   // Normal path carries its 31-bit truncated magnitude separately.
   logic [30:0] norm_mag_ff, norm_mag_in;
   logic        is_norm_ff, is_norm_in;
   always_comb begin
      is_norm_in  = (ex != 11'h7FF) && (ex < 11'd1151) && (ex >= 11'd897);
      norm_mag_in = {ex[7:0] - 8'd128, frac[51:29]};
   end

   always_comb begin
      logic [31:0] mag;
      mag = '0;
      q_sum = '0;
      if (is_norm_ff) begin
         mag = {1'b0, norm_mag_ff} + {31'd0, d1_ff.round_up};
      end else begin
         q_sum = {1'b0, d1_ff.q} + {24'd0, d1_ff.round_up};
         mag = {7'd0, q_sum};
      end
      d2_in.raw   = d1_ff.raw;
      d2_in.etype = d1_ff.etype;
      if (d1_ff.special) begin
         d2_in.single = {d1_ff.sign, 31'd0} | d1_ff.fixed_val;
      end else if (mag >= F32_INF) begin
         d2_in.single = {d1_ff.sign, 31'd0} | F32_INF;
      end else begin
         d2_in.single = {d1_ff.sign, mag[30:0]};
      end
   end

   assign v1_in = in_valid;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff       <= d1_in;
         norm_mag_ff <= norm_mag_in;
         is_norm_ff  <= is_norm_in;
         d2_ff       <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = d2_ff;

endmodule

// ===== rtl/vefc_narrow.sv =====
// ---------------------------------------------------------------------------
// vefc_narrow
// Third stage: half and bfloat16 narrowing and final result selection.
// ---------------------------------------------------------------------------
module vefc_narrow (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  vefc_pkg::s2_data_type     in_data,
   output logic                      out_valid,
   output logic [63:0]               out_bits,
   output logic [3:0]                out_bytes
);
   import vefc_pkg::*;

   logic        v_ff;
   logic [63:0] bits_ff, bits_in;
   logic [3:0]  bytes_ff, bytes_in;

   logic [31:0] f, sgn, x, scaled, h, bf, m;
   logic [7:0]  e, eff;
   logic [4:0]  sh;
   logic [31:0] q, rem, halfb;
   logic [15:0] half_res;

   always_comb begin
      f   = in_data.single;
      sgn = f & F32_SIGN;
      x   = (f ^ sgn) & HALF_TRUNC;
      e   = x[30:23];
      m   = {8'd0, 1'b0, x[22:0]};
      eff = e;
      q = '0; rem = '0; halfb = '0; sh = '0;
      if (e == 8'd255) begin
         scaled = F32_INF;
      end else if (e >= 8'd113) begin
         scaled = x - (32'd112 << 23);
      end else begin
         if (e != 8'd0) m[23] = 1'b1; else eff = 8'd1;
         // shift is 1..112; anything past 24 leaves nothing
         if ((8'd113 - eff) > 8'd25) begin
            scaled = '0;
         end else begin
            sh    = 5'((8'd113 - eff));
            q     = m >> sh;
            rem   = m & ((32'd1 << sh) - 32'd1);
            halfb = 32'd1 << (sh - 5'd1);
            scaled = q + {31'd0, (rem > halfb) || ((rem == halfb) && q[0])};
         end
      end
      h = scaled - HALF_TRUNC;
      if (h > HALF_INF_POS) h = HALF_INF_POS;
      half_res = h[28:13] | sgn[31:16];
      bf = f + {31'd0, f[16]} + BF16_HALF;
      unique case (elem_type'(in_data.etype))
         ELEM_F64: begin
            bits_in = in_data.raw; bytes_in = 4'd8;
         end
         ELEM_F16: begin
            bits_in = {48'd0, half_res}; bytes_in = 4'd2;
         end
         ELEM_BF16: begin
            bits_in = {48'd0, bf[31:16]}; bytes_in = 4'd2;
         end
         default: begin
            bits_in = {32'd0, f}; bytes_in = 4'd4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bits_ff  <= bits_in;
         bytes_ff <= bytes_in;
      end
   end

   assign out_valid = v_ff;
   assign out_bits  = bits_ff;
   assign out_bytes = bytes_ff;

endmodule

// ===== rtl/vector_element_float_converter_unit.sv =====
// ---------------------------------------------------------------------------
// vector_element_float_converter_unit
// Converts IEEE doubles to float32, float64, float16 or bfloat16 elements.
// ---------------------------------------------------------------------------
// One beat is accepted per cycle while req_stall is low, and its result
// leaves through three register stages (align, round to single, narrow).
// A stalled result (rsp_valid with rsp_stall) freezes the whole pipeline,
// and stalls the request side in the same cycle. Write csr_ only while idle.
module vector_element_float_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_encoded_bits,
   output logic [3:0]  rsp_element_bytes
);
   import vefc_pkg::*;

   logic [1:0]  etype_ff;
   logic        advance;
   logic        mid_valid;
   s2_data_type mid_data;

   // advance when the output slot is free or being drained
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         etype_ff <= ELEM_F32;
      end else if (csr_write_enable) begin
         etype_ff <= csr_write_data;
      end
   end

   vefc_to_single u_single (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_raw    (req_value_bits),
      .in_etype  (etype_ff),
      .out_valid (mid_valid),
      .out_data  (mid_data)
   );

   vefc_narrow u_narrow (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_bits  (rsp_encoded_bits),
      .out_bytes (rsp_element_bytes)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encoded_bits))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_bytes == 4'd2 || rsp_element_bytes == 4'd4
                    || rsp_element_bytes == 4'd8)
      else $error("bad element size");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_bytes != 4'd8 |-> rsp_encoded_bits[63:32] == '0)
      else $error("upper bits set");

endmodule

// ===== dv/vector_element_float_converter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// vector_element_float_converter_unit_tb
// Drives doubles through the converter under every element type, predicts
// each encoding from the input bits and checks results in order.
// ---------------------------------------------------------------------------
module vector_element_float_converter_unit_tb;
   import vefc_pkg::*;

   class conv_scoreboard;
      logic [63:0] exp_bits[$];
      logic [3:0]  exp_bytes[$];
      int          mismatches;
      int          checked;

      function logic [63:0] rne_shift(logic [63:0] m, int unsigned sh);
         logic [63:0] q, rem, half;
         if (sh == 0) return m;
         if (sh >= 64) return 64'd0;
         q = m >> sh;
         rem = m & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
         return q;
      endfunction

      function logic [31:0] to_single(logic [63:0] d);
         logic [31:0] sgn;
         logic [10:0] ex;
         logic [51:0] frac;
         logic [63:0] q;
         int          e;
         sgn = {d[63], 31'd0};
         ex = d[62:52];
         frac = d[51:0];
         if (ex == 11'h7FF) begin
            if (frac == 0) return sgn | F32_INF;
            return sgn | F32_INF | 32'h0040_0000 | 32'(frac >> 29);
         end
         if (ex == 0) return sgn;
         e = int'(ex) - 896;
         if (e >= 255) return sgn | F32_INF;
         if (e >= 1) q = rne_shift((64'(e) << 52) | 64'(frac), 29);
         else q = rne_shift(64'(frac) | (64'd1 << 52), 926 - int'(ex));
         if (q >= 64'(F32_INF)) return sgn | F32_INF;
         return sgn | q[31:0];
      endfunction

      function logic [15:0] to_half(logic [31:0] f);
         logic [31:0] sgn, x, e, sc, h, m, eff;
         sgn = f & F32_SIGN;
         x = (f ^ sgn) & HALF_TRUNC;
         e = x >> 23;
         if (e == 255) sc = F32_INF;
         else if (e >= 113) sc = x - (32'd112 << 23);
         else begin
            m = x & 32'h007F_FFFF;
            eff = e;
            if (e != 0) m = m | 32'h0080_0000;
            else eff = 1;
            sc = 32'(rne_shift(64'(m), 113 - eff));
         end
         h = sc - HALF_TRUNC;
         if (h > HALF_INF_POS) h = HALF_INF_POS;
         return 16'((h >> 13) | (sgn >> 16));
      endfunction

      function void note_input(logic [63:0] d, elem_type t);
         logic [31:0] s, f;
         s = to_single(d);
         case (t)
            ELEM_F64: begin
               exp_bits.push_back(d); exp_bytes.push_back(4'd8);
            end
            ELEM_F16: begin
               exp_bits.push_back(64'(to_half(s))); exp_bytes.push_back(4'd2);
            end
            ELEM_BF16: begin
               f = s + 32'(s[16]) + BF16_HALF;
               exp_bits.push_back(64'(f[31:16])); exp_bytes.push_back(4'd2);
            end
            default: begin
               exp_bits.push_back(64'(s)); exp_bytes.push_back(4'd4);
            end
         endcase
      endfunction

      function void check_result(logic [63:0] b, logic [3:0] n);
         logic [63:0] eb;
         logic [3:0]  en;
         checked++;
         if (exp_bits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat bits=%h bytes=%0d", b, n);
            return;
         end
         eb = exp_bits.pop_front();
         en = exp_bytes.pop_front();
         if (eb !== b || en !== n) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h/%0d got %h/%0d", eb, en, b, n);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_write_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [63:0] req_value_bits = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_encoded_bits;
   logic [3:0]  rsp_element_bytes;

   conv_scoreboard sb = new();
   elem_type cur_type = ELEM_F32;
   bit       quiet_phase = 0;
   int       idle_cycles = 0;
   int       type_hits[4];

   vector_element_float_converter_unit DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // score beats at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_value_bits, cur_type);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_encoded_bits, rsp_element_bytes);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("watchdog: no progress");
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // receiver stalls in random bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   task automatic send_value(input logic [63:0] d);
      int n;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_value_bits <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      type_hits[cur_type]++;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 0;
      @(negedge clock);
      while (sb.exp_bits.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_type(input elem_type t);
      drain_pipe();
      csr_write_enable <= 1;
      csr_write_data <= t;
      @(negedge clock);
      csr_write_enable <= 0;
      cur_type = t;
   endtask

   function automatic logic [63:0] rand_double();
      logic [63:0] d;
      logic [10:0] ex;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: ex = 11'h7FF;
         1: ex = 11'h000;
         2: ex = 11'($urandom_range(850, 930));   // single subnormal and underflow edge
         3: ex = 11'($urandom_range(1000, 1040)); // half range
         4: ex = 11'($urandom_range(1140, 1160)); // single overflow edge
         default: ex = d[62:52];
      endcase
      d[62:52] = ex;
      if ($urandom_range(0, 5) == 0) d[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'd0;
      return d;
   endfunction

   initial begin
      logic [63:0] directed[$];
      elem_type types[4];
      types = '{ELEM_F32, ELEM_F64, ELEM_F16, ELEM_BF16};
      directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                   64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h7FEF_FFFF_FFFF_FFFF, 64'h47EF_FFFF_F000_0000, 64'h0000_0000_0000_0001,
                   64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0001, 64'h3810_0000_0000_0000,
                   64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000, 64'h40EF_FE00_0000_0000,
                   64'h40F0_0000_0000_0000, 64'h3E70_0000_0000_0000, 64'hBFF5_5555_5555_5555};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (types[k]) begin
         set_type(types[k]);
         foreach (directed[i]) send_value(directed[i]);
      end
      // hold off until the pipe is empty once
      drain_pipe();
      for (int r = 0; r < 1100; r++) begin
         if (r % 120 == 0) set_type(elem_type'($urandom_range(0, 3)));
         if (r == 1000) quiet_phase = 1;
         send_value(rand_double());
      end
      set_type(ELEM_F16);
      send_value(64'h4000_0000_0000_0000);
      drain_pipe();
      $display("checked %0d results; beats per type f32=%0d f64=%0d f16=%0d bf16=%0d",
               sb.checked, type_hits[0], type_hits[1], type_hits[2], type_hits[3]);
      if (sb.mismatches == 0 && sb.exp_bits.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
